// ===== hw/rtl/wfea_pkg.sv =====
package wfea_pkg;

    localparam logic [32:0] ARENA_BYTES_DEF = 33'd536870912;
    localparam int          MAX_EXTENTS_DEF = 64;

    localparam int HDR_BYTES  = 8;
    localparam int PAD_BYTES  = 8;
    localparam int MIN_REMAIN = 24;

    typedef enum logic {
        OP_ALLOC   = 1'b0,
        OP_RELEASE = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOFIT   = 2'd1,
        ST_FULL    = 2'd2,
        ST_OVERLAP = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        FSM_INIT,
        FSM_IDLE,
        FSM_SCAN,
        FSM_EDIT,
        FSM_HOLD
    } fsm_t;

    // command broadcast along the row of extent cells
    typedef struct packed {
        logic rotate;
        logic wr_en;
        logic drop_en;
        logic ins_en;
    } cell_ctrl_t;

endpackage

// ===== hw/rtl/wfea_cell.sv =====
module wfea_cell import wfea_pkg::*; #(
    parameter int IW  = 6,
    parameter int XW  = 30,
    parameter int IDX = 0
) (
    input  logic          aclk,
    input  cell_ctrl_t    ctrl,
    input  logic [IW-1:0] wr_idx,
    input  logic [IW-1:0] drop_idx,
    input  logic [XW-1:0] wr_start,
    input  logic [XW-1:0] wr_len,
    input  logic [XW-1:0] up_start,
    input  logic [XW-1:0] up_len,
    input  logic [XW-1:0] dn_start,
    input  logic [XW-1:0] dn_len,
    output logic [XW-1:0] start_q,
    output logic [XW-1:0] len_q
);

    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    logic [XW-1:0] start_reg, len_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.rotate) begin
            start_reg <= up_start;
            len_reg   <= up_len;
        end else if (ctrl.wr_en && MY_IDX == wr_idx) begin
            start_reg <= wr_start;
            len_reg   <= wr_len;
        end else if (ctrl.drop_en && MY_IDX >= drop_idx) begin
            start_reg <= up_start;
            len_reg   <= up_len;
        end else if (ctrl.ins_en && MY_IDX > wr_idx) begin
            start_reg <= dn_start;
            len_reg   <= dn_len;
        end
    end

    assign start_q = start_reg;
    assign len_q   = len_reg;

endmodule

// ===== hw/rtl/worst_fit_extent_allocator.sv =====
// Worst-fit extent allocator. Free extents sit in a row of MAX_EXTENTS cells kept in address
// order. For every word the row rotates once through all cells so the controller sees each
// extent at the head cell, then the edit state applies the edit (write, insert with shift, or
// remove with shift) across all cells at once, then the result word is loaded into the output
// register. A new word is taken only after the previous result has been loaded into the output
// register, so a stalled output holds off the input. After reset the INIT state loads the
// whole-arena extent.
module worst_fit_extent_allocator import wfea_pkg::*; #(
    parameter logic [32:0] ARENA_BYTES = ARENA_BYTES_DEF,
    parameter int          MAX_EXTENTS = MAX_EXTENTS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // request_length[29:0], free_address[59:30], block_length[89:60]
    input  logic [95:0]  s_axis_tdata,
    // opcode[0]
    input  logic [0:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // grant_address[29:0], granted_length[59:30], free_extent_count[66:60],
    // active_allocations[92:67], free_total[122:93]
    output logic [127:0] m_axis_tdata,
    // status[1:0]
    output logic [1:0]   m_axis_tuser
);

    localparam int XW = $clog2(ARENA_BYTES + 33'd1);
    localparam int IW = $clog2(MAX_EXTENTS);
    localparam int CW = $clog2(MAX_EXTENTS + 1);
    localparam int EW = ((XW > 31) ? XW : 31) + 2;

    localparam logic [EW-1:0] ARENA_E = EW'(ARENA_BYTES);
    localparam logic [IW-1:0] LAST_IDX = IW'(MAX_EXTENTS - 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_EXTENTS);

    fsm_t state_reg, state_next;

    logic [XW-1:0] cs [MAX_EXTENTS];
    logic [XW-1:0] cl [MAX_EXTENTS];

    cell_ctrl_t    ctrl;
    logic [IW-1:0] wr_idx, drop_idx;
    logic [XW-1:0] wr_start, wr_len;

    genvar k;
    generate
        for (k = 0; k < MAX_EXTENTS; k++) begin : g_cell
            localparam int UP = (k + 1) % MAX_EXTENTS;
            localparam int DN = (k == 0) ? 0 : k - 1;
            wfea_cell #(.IW(IW), .XW(XW), .IDX(k)) u_cell (
                .aclk    (aclk),
                .ctrl    (ctrl),
                .wr_idx  (wr_idx),
                .drop_idx(drop_idx),
                .wr_start(wr_start),
                .wr_len  (wr_len),
                .up_start(cs[UP]),
                .up_len  (cl[UP]),
                .dn_start(cs[DN]),
                .dn_len  (cl[DN]),
                .start_q (cs[k]),
                .len_q   (cl[k])
            );
        end
    endgenerate

    // captured request
    opcode_t       op_reg;
    logic [EW-1:0] need_reg, first_reg, bl_reg;
    logic          fa_low_reg;

    // scan results
    logic [IW-1:0] sc_reg;
    logic          found_reg;
    logic [IW-1:0] best_idx_reg;
    logic [XW-1:0] best_start_reg, best_len_reg;
    logic [CW-1:0] p_reg;
    logic          hp_reg, hn_reg;
    logic [XW-1:0] prev_start_reg, prev_len_reg, next_start_reg, next_len_reg;

    // running counts
    logic [CW-1:0] total_reg;
    logic [25:0]   live_reg;
    logic [XW-1:0] free_reg;

    status_t       status_reg;
    logic [29:0]   ga_reg, gl_reg;

    logic          m_tvalid_reg;
    logic [127:0]  m_tdata_reg;
    logic [1:0]    m_tuser_reg;

    logic          s_fire, out_free;
    logic [EW-1:0] s_req, s_fa, s_bl;

    assign s_axis_tready = (state_reg == FSM_IDLE);
    assign s_fire   = s_axis_tvalid && s_axis_tready;
    assign out_free = !m_tvalid_reg || m_axis_tready;
    assign s_req = EW'(s_axis_tdata[29:0]);
    assign s_fa  = EW'(s_axis_tdata[59:30]);
    assign s_bl  = EW'(s_axis_tdata[89:60]);

    // head cell during the scan
    logic [EW-1:0] h_start, h_len;
    logic          h_live;
    assign h_start = EW'(cs[0]);
    assign h_len   = EW'(cl[0]);
    assign h_live  = CW'(sc_reg) < total_reg;

    // edit decision
    logic [EW-1:0] prev_end, rel_end, remain;
    logic          rel_bad, mp, mn;
    status_t       ed_status;
    logic [EW-1:0] ed_gl;
    logic          ed_tot_inc, ed_tot_dec;
    logic [IW-1:0] p_idx;

    assign prev_end = EW'(prev_start_reg) + EW'(prev_len_reg);
    assign rel_end  = first_reg + bl_reg;
    assign remain   = EW'(best_len_reg) - need_reg;
    assign p_idx    = p_reg[IW-1:0];
    assign rel_bad  = fa_low_reg || bl_reg == '0 || rel_end > ARENA_E
                   || (hp_reg && prev_end > first_reg)
                   || (hn_reg && EW'(next_start_reg) < rel_end);
    assign mp = hp_reg && prev_end == first_reg;
    assign mn = hn_reg && EW'(next_start_reg) == rel_end;

    always_comb begin
        ctrl       = '0;
        wr_idx     = '0;
        drop_idx   = '0;
        wr_start   = '0;
        wr_len     = '0;
        ed_status  = ST_OK;
        ed_gl      = '0;
        ed_tot_inc = 1'b0;
        ed_tot_dec = 1'b0;
        unique case (state_reg)
            FSM_INIT: begin
                ctrl.wr_en = 1'b1;
                wr_len     = ARENA_BYTES[XW-1:0];
            end
            FSM_SCAN: begin
                ctrl.rotate = 1'b1;
            end
            FSM_EDIT: begin
                if (op_reg == OP_ALLOC) begin
                    if (!found_reg) begin
                        ed_status = ST_NOFIT;
                    end else if (remain < EW'(MIN_REMAIN)) begin
                        ed_gl        = EW'(best_len_reg);
                        ctrl.drop_en = 1'b1;
                        drop_idx     = best_idx_reg;
                        ed_tot_dec   = 1'b1;
                    end else begin
                        ed_gl      = need_reg;
                        ctrl.wr_en = 1'b1;
                        wr_idx     = best_idx_reg;
                        wr_start   = XW'(EW'(best_start_reg) + need_reg);
                        wr_len     = XW'(remain);
                    end
                end else begin
                    if (rel_bad) begin
                        ed_status = ST_OVERLAP;
                    end else if (mp && mn) begin
                        ctrl.wr_en   = 1'b1;
                        wr_idx       = p_idx - IW'(1);
                        wr_start     = prev_start_reg;
                        wr_len       = XW'(EW'(prev_len_reg) + bl_reg + EW'(next_len_reg));
                        ctrl.drop_en = 1'b1;
                        drop_idx     = p_idx;
                        ed_tot_dec   = 1'b1;
                    end else if (mp) begin
                        ctrl.wr_en = 1'b1;
                        wr_idx     = p_idx - IW'(1);
                        wr_start   = prev_start_reg;
                        wr_len     = XW'(EW'(prev_len_reg) + bl_reg);
                    end else if (mn) begin
                        ctrl.wr_en = 1'b1;
                        wr_idx     = p_idx;
                        wr_start   = XW'(first_reg);
                        wr_len     = XW'(EW'(next_len_reg) + bl_reg);
                    end else if (total_reg >= MAX_CNT) begin
                        ed_status = ST_FULL;
                    end else begin
                        ctrl.wr_en  = 1'b1;
                        ctrl.ins_en = 1'b1;
                        wr_idx      = p_idx;
                        wr_start    = XW'(first_reg);
                        wr_len      = XW'(bl_reg);
                        ed_tot_inc  = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            FSM_INIT: state_next = FSM_IDLE;
            FSM_IDLE: if (s_fire) state_next = FSM_SCAN;
            FSM_SCAN: if (sc_reg == LAST_IDX) state_next = FSM_EDIT;
            FSM_EDIT: state_next = FSM_HOLD;
            FSM_HOLD: if (out_free) state_next = FSM_IDLE;
            default:  state_next = FSM_INIT;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FSM_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    // request capture and scan
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            op_reg     <= opcode_t'(s_axis_tuser[0]);
            need_reg   <= (s_req + EW'(HDR_BYTES + PAD_BYTES + 7)) & ~EW'(7);
            first_reg  <= s_fa - EW'(HDR_BYTES);
            fa_low_reg <= s_fa < EW'(HDR_BYTES);
            bl_reg     <= s_bl;
            sc_reg     <= '0;
            found_reg  <= 1'b0;
            p_reg      <= '0;
            hp_reg     <= 1'b0;
            hn_reg     <= 1'b0;
        end else if (state_reg == FSM_SCAN) begin
            sc_reg <= sc_reg + IW'(1);
            if (h_live) begin
                if (op_reg == OP_ALLOC) begin
                    if (h_len >= need_reg && (!found_reg || cl[0] > best_len_reg)) begin
                        found_reg      <= 1'b1;
                        best_idx_reg   <= sc_reg;
                        best_start_reg <= cs[0];
                        best_len_reg   <= cl[0];
                    end
                end else if (h_start < first_reg) begin
                    p_reg          <= p_reg + CW'(1);
                    hp_reg         <= 1'b1;
                    prev_start_reg <= cs[0];
                    prev_len_reg   <= cl[0];
                end else if (!hn_reg) begin
                    hn_reg         <= 1'b1;
                    next_start_reg <= cs[0];
                    next_len_reg   <= cl[0];
                end
            end
        end
    end

    // counts and result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg <= CW'(1);
            live_reg  <= '0;
            free_reg  <= ARENA_BYTES[XW-1:0];
        end else if (state_reg == FSM_EDIT && ed_status == ST_OK) begin
            if (ed_tot_inc) total_reg <= total_reg + CW'(1);
            if (ed_tot_dec) total_reg <= total_reg - CW'(1);
            if (op_reg == OP_ALLOC) begin
                free_reg <= XW'(EW'(free_reg) - ed_gl);
                if (live_reg != '1) live_reg <= live_reg + 26'd1;
            end else begin
                free_reg <= XW'(EW'(free_reg) + bl_reg);
                if (live_reg != '0) live_reg <= live_reg - 26'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == FSM_EDIT) begin
            status_reg <= ed_status;
            if (ed_status == ST_OK && op_reg == OP_ALLOC) begin
                ga_reg <= 30'(EW'(best_start_reg) + EW'(HDR_BYTES));
                gl_reg <= 30'(ed_gl);
            end else begin
                ga_reg <= '0;
                gl_reg <= '0;
            end
        end
    end

    // output register
    logic [CW+6:0]  total_ext;
    logic [XW+29:0] free_ext;
    assign total_ext = (CW + 7)'(total_reg);
    assign free_ext  = (XW + 30)'(free_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == FSM_HOLD && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == FSM_HOLD && out_free) begin
            m_tuser_reg <= status_reg;
            m_tdata_reg <= {5'd0, free_ext[29:0], live_reg, total_ext[6:0], gl_reg, ga_reg};
        end
    end

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;
    assign m_axis_tuser  = m_tuser_reg;

endmodule
